@@ sv/fpsched_pkg.sv @@
// ----------------------------------------------------------------------------
// fpsched_pkg
// Shared widths, codes and the sequencer state type of the frame pacing
// scheduler.
// ----------------------------------------------------------------------------
package fpsched_pkg;

  localparam int unsigned FINE_W      = 63;  // fine counter
  localparam int unsigned WIDE_W      = 64;  // signed deadline arithmetic
  localparam int unsigned ALU_W       = WIDE_W + 1;
  localparam int unsigned MS_W        = 32;
  localparam int unsigned TPM_W       = 32;
  localparam int unsigned FPS_W       = 10;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  // ticks_per_ms * 1000 stays below 2^42
  localparam int unsigned PROD_W      = 42;
  // period * 100 stays below 2^49
  localparam int unsigned P100_W      = 49;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [PROD_W-1:0] MS_PER_S        = PROD_W'(1000);
  localparam logic [P100_W-1:0] GAP_LIMIT       = P100_W'(100);
  localparam logic [MS_W-1:0]   RENDER_STALE_MS = MS_W'(5000);

  // input beat kinds
  localparam logic [MODE_W-1:0] MODE_CHECK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RESYNC   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DL_RESET = 2'd2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_TICKS_PER_MS = 3'd0;
  localparam logic [IDX_W-1:0] CFG_MAX_FPS      = 3'd1;
  localparam logic [IDX_W-1:0] CFG_MIN_FPS      = 3'd2;
  localparam logic [IDX_W-1:0] CFG_RENDER_ONLY  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_FIXED_FRAME  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SCALE,
    S_ELAP,
    S_GAP,
    S_CLAMP,
    S_TEST,
    S_CAP,
    S_ADV,
    S_LAG,
    S_FIN,
    S_DONE
  } state_t;

endpackage

@@ sv/frame_pacing_skip_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// frame_pacing_skip_scheduler_core
// Frame rate limiter with frame skip: decides per frame check whether the
// game state moves and whether a frame is drawn.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  in_     | in  | tuser: mode; tdata: fine_tick, ms_tick
//  out_    | out | tdata: do_move, do_render, elapsed_ms
//  cfg_    | in  | cfg_index selects register, cfg_data carries the value
//
//  A resync, deadline-reset or unused-mode beat goes straight to S_DONE. A frame
//  check runs one division (fixed mode, or min_fps zero) and a second one when
//  the min-fps cap needs it; both use the radix-2 restoring divider, and the
//  remaining sequencer steps share the 65-bit add/compare unit.
//  in_tready is high only while the sequencer is idle. The result sits in an
//  output register, so the next beat is taken while it waits; a finished
//  result waits in S_DONE while the output register is still full.
//  Reset (rst_n low, synchronous) restores register defaults and clears the
//  deadline, both ms marks and the frame-seen flag. cfg_ready is always high.
//
module frame_pacing_skip_scheduler_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input beats
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [62:0] fine_tick, [94:63] ms_tick, [95] zero
  input  logic [fpsched_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] mode
  input  logic [fpsched_pkg::MODE_W-1:0]       in_tuser,
  // result beats
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] do_move, [1] do_render, [33:2] elapsed_ms, [39:34] zero
  output logic [fpsched_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fpsched_pkg::IDX_W-1:0]        cfg_index,
  input  logic [fpsched_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned FINE_W = fpsched_pkg::FINE_W;
  localparam int unsigned WIDE_W = fpsched_pkg::WIDE_W;
  localparam int unsigned ALU_W  = fpsched_pkg::ALU_W;
  localparam int unsigned MS_W   = fpsched_pkg::MS_W;
  localparam int unsigned FPS_W  = fpsched_pkg::FPS_W;
  localparam int unsigned PROD_W = fpsched_pkg::PROD_W;
  localparam int unsigned P100_W = fpsched_pkg::P100_W;
  localparam int unsigned CNT_W  = fpsched_pkg::CNT_W;

  // configuration
  logic [fpsched_pkg::TPM_W-1:0] tpm_r, tpm_nxt;
  logic [FPS_W-1:0]              max_fps_r, max_fps_nxt;
  logic [FPS_W-1:0]              min_fps_r, min_fps_nxt;
  logic                          ro_en_r, ro_en_nxt;
  logic                          fixed_r, fixed_nxt;

  // architectural state
  logic [WIDE_W-1:0]             dl_r, dl_nxt;          // frame deadline, signed
  logic [MS_W-1:0]               last_move_r, last_move_nxt;
  logic [MS_W-1:0]               last_rend_r, last_rend_nxt;
  logic                          seen_r, seen_nxt;

  // sequencer
  fpsched_pkg::state_t           state_r, state_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // per-beat working registers
  logic [FINE_W-1:0]             now_r, now_nxt;
  logic [MS_W-1:0]               ms_r, ms_nxt;
  logic [PROD_W-1:0]             prod_r, prod_nxt;
  logic [PROD_W-1:0]             period_r, period_nxt;
  logic [PROD_W-1:0]             cap_r, cap_nxt;
  logic [PROD_W-1:0]             adv_r, adv_nxt;
  logic [P100_W-1:0]             p100_r, p100_nxt;
  logic [WIDE_W-1:0]             el_r, el_nxt;          // elapsed, signed
  logic [WIDE_W-1:0]             lag_r, lag_nxt;        // now - new deadline
  logic                          res_move_r, res_move_nxt;
  logic                          res_rend_r, res_rend_nxt;
  logic [MS_W-1:0]               res_ms_r, res_ms_nxt;
  logic [fpsched_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // divider: quotient shifts in where the dividend shifts out
  logic [PROD_W-1:0]             div_q_r, div_q_nxt;
  logic [FPS_W-1:0]              div_rem_r, div_rem_nxt;
  logic [FPS_W-1:0]              div_d_r, div_d_nxt;
  logic [CNT_W-1:0]              div_cnt_r, div_cnt_nxt;
  logic                          div_min_r, div_min_nxt; // second division running

  logic [FPS_W:0]                rem_sh;
  logic                          rem_ge;
  logic [FPS_W-1:0]              rem_next;
  logic [PROD_W-1:0]             q_next;
  logic                          div_last;

  // shared add/compare unit, 65 bits so signed compares never overflow
  logic signed [ALU_W-1:0]       alu_a, alu_b, alu_res;
  logic                          alu_sub;
  logic                          alu_neg;

  logic                          in_acc;
  logic                          out_free;
  logic [MS_W-1:0]               since_ms;
  logic [MS_W-1:0]               rend_age;
  logic                          stale;
  logic [FINE_W-1:0]             in_fine;
  logic [MS_W-1:0]               in_ms;

  assign in_fine   = in_tdata[FINE_W-1:0];
  assign in_ms     = in_tdata[FINE_W+MS_W-1:FINE_W];
  assign in_tready = (state_r == fpsched_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // one restoring divide step per cycle
  assign rem_sh   = {div_rem_r, div_q_r[PROD_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, div_d_r});
  assign rem_next = rem_ge ? FPS_W'(rem_sh - {1'b0, div_d_r}) : rem_sh[FPS_W-1:0];
  assign q_next   = {div_q_r[PROD_W-2:0], rem_ge};
  assign div_last = (div_cnt_r == CNT_W'(PROD_W - 1));

  assign since_ms = ms_r - last_move_r;
  assign rend_age = ms_r - last_rend_r;
  assign stale    = (rend_age > fpsched_pkg::RENDER_STALE_MS);

  // operand select for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state_r)
      fpsched_pkg::S_ELAP: begin
        alu_a = {2'b00, now_r};
        alu_b = {dl_r[WIDE_W-1], dl_r};
      end
      fpsched_pkg::S_GAP: begin
        alu_a = {{(ALU_W-P100_W){1'b0}}, p100_r};
        alu_b = {el_r[WIDE_W-1], el_r};
      end
      fpsched_pkg::S_CLAMP: begin
        alu_a = {2'b00, now_r};
        alu_b = {{(ALU_W-PROD_W){1'b0}}, period_r};
      end
      fpsched_pkg::S_TEST: begin
        alu_a = {el_r[WIDE_W-1], el_r};
        alu_b = {{(ALU_W-PROD_W){1'b0}}, period_r};
      end
      fpsched_pkg::S_CAP: begin
        alu_a = {el_r[WIDE_W-1], el_r};
        alu_b = {{(ALU_W-PROD_W){1'b0}}, cap_r};
      end
      fpsched_pkg::S_ADV: begin
        alu_a   = {dl_r[WIDE_W-1], dl_r};
        alu_b   = {{(ALU_W-PROD_W){1'b0}}, adv_r};
        alu_sub = 1'b0;
      end
      fpsched_pkg::S_LAG: begin
        alu_a = {2'b00, now_r};
        alu_b = {dl_r[WIDE_W-1], dl_r};
      end
      fpsched_pkg::S_FIN: begin
        alu_a = {{(ALU_W-PROD_W){1'b0}}, period_r};
        alu_b = {lag_r[WIDE_W-1], lag_r};
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    alu_neg = alu_res[ALU_W-1];
  end

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    tpm_nxt       = tpm_r;
    max_fps_nxt   = max_fps_r;
    min_fps_nxt   = min_fps_r;
    ro_en_nxt     = ro_en_r;
    fixed_nxt     = fixed_r;
    dl_nxt        = dl_r;
    last_move_nxt = last_move_r;
    last_rend_nxt = last_rend_r;
    seen_nxt      = seen_r;
    now_nxt       = now_r;
    ms_nxt        = ms_r;
    prod_nxt      = prod_r;
    period_nxt    = period_r;
    cap_nxt       = cap_r;
    adv_nxt       = adv_r;
    p100_nxt      = p100_r;
    el_nxt        = el_r;
    lag_nxt       = lag_r;
    res_move_nxt  = res_move_r;
    res_rend_nxt  = res_rend_r;
    res_ms_nxt    = res_ms_r;
    div_q_nxt     = div_q_r;
    div_rem_nxt   = div_rem_r;
    div_d_nxt     = div_d_r;
    div_cnt_nxt   = div_cnt_r;
    div_min_nxt   = div_min_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      case (cfg_index)
        fpsched_pkg::CFG_TICKS_PER_MS: tpm_nxt     = cfg_data;
        fpsched_pkg::CFG_MAX_FPS:      max_fps_nxt = cfg_data[FPS_W-1:0];
        fpsched_pkg::CFG_MIN_FPS:      min_fps_nxt = cfg_data[FPS_W-1:0];
        fpsched_pkg::CFG_RENDER_ONLY:  ro_en_nxt   = cfg_data[0];
        fpsched_pkg::CFG_FIXED_FRAME:  fixed_nxt   = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      fpsched_pkg::S_IDLE: begin
        if (in_acc) begin
          now_nxt      = in_fine;
          ms_nxt       = in_ms;
          res_move_nxt = 1'b0;
          res_rend_nxt = 1'b0;
          res_ms_nxt   = '0;
          state_nxt    = fpsched_pkg::S_DONE;
          case (in_tuser)
            fpsched_pkg::MODE_CHECK: begin
              state_nxt = fpsched_pkg::S_MUL;
            end
            fpsched_pkg::MODE_RESYNC: begin
              dl_nxt        = {1'b0, in_fine};
              last_move_nxt = in_ms;
            end
            fpsched_pkg::MODE_DL_RESET: begin
              dl_nxt = {1'b0, in_fine};
            end
            default: ;  // unused mode: no state change
          endcase
        end
      end

      fpsched_pkg::S_MUL: begin
        prod_nxt    = PROD_W'(tpm_r) * fpsched_pkg::MS_PER_S;
        div_q_nxt   = PROD_W'(tpm_r) * fpsched_pkg::MS_PER_S;
        div_rem_nxt = '0;
        div_cnt_nxt = '0;
        div_min_nxt = 1'b0;
        div_d_nxt   = (max_fps_r == '0) ? FPS_W'(1) : max_fps_r;
        state_nxt   = fpsched_pkg::S_DIV;
      end

      fpsched_pkg::S_DIV: begin
        div_q_nxt   = q_next;
        div_rem_nxt = rem_next;
        div_cnt_nxt = div_cnt_r + CNT_W'(1);
        if (div_last) begin
          if (div_min_r) begin
            cap_nxt   = q_next;
            state_nxt = fpsched_pkg::S_SCALE;
          end else begin
            period_nxt = q_next;
            cap_nxt    = q_next;
            if (!fixed_r && (min_fps_r != '0)) begin
              // second pass for the min-fps cap
              div_q_nxt   = prod_r;
              div_rem_nxt = '0;
              div_cnt_nxt = '0;
              div_min_nxt = 1'b1;
              div_d_nxt   = min_fps_r;
            end else begin
              state_nxt = fpsched_pkg::S_SCALE;
            end
          end
        end
      end

      fpsched_pkg::S_SCALE: begin
        p100_nxt  = P100_W'(period_r) * fpsched_pkg::GAP_LIMIT;
        state_nxt = fpsched_pkg::S_ELAP;
      end

      fpsched_pkg::S_ELAP: begin
        el_nxt    = alu_res[WIDE_W-1:0];
        state_nxt = fpsched_pkg::S_GAP;
      end

      fpsched_pkg::S_GAP: begin
        // negative: elapsed beyond 100 periods, clamp to one period
        if (alu_neg) begin
          el_nxt    = {{(WIDE_W-PROD_W){1'b0}}, period_r};
          state_nxt = fpsched_pkg::S_CLAMP;
        end else begin
          state_nxt = fpsched_pkg::S_TEST;
        end
      end

      fpsched_pkg::S_CLAMP: begin
        dl_nxt    = alu_res[WIDE_W-1:0];
        state_nxt = fpsched_pkg::S_TEST;
      end

      fpsched_pkg::S_TEST: begin
        if (!alu_neg) begin
          if (fixed_r) begin
            adv_nxt   = period_r;
            state_nxt = fpsched_pkg::S_ADV;
          end else begin
            state_nxt = fpsched_pkg::S_CAP;
          end
        end else begin
          // between frames
          state_nxt = fpsched_pkg::S_DONE;
          if (ro_en_r) begin
            last_rend_nxt = ms_r;
            res_move_nxt  = !seen_r;
            res_rend_nxt  = 1'b1;
            res_ms_nxt    = MS_W'(1);
          end
        end
      end

      fpsched_pkg::S_CAP: begin
        // elapsed is at least one period here and below the cap when chosen
        adv_nxt   = alu_neg ? el_r[PROD_W-1:0] : cap_r;
        state_nxt = fpsched_pkg::S_ADV;
      end

      fpsched_pkg::S_ADV: begin
        dl_nxt    = alu_res[WIDE_W-1:0];
        state_nxt = fpsched_pkg::S_LAG;
      end

      fpsched_pkg::S_LAG: begin
        lag_nxt   = alu_res[WIDE_W-1:0];
        state_nxt = fpsched_pkg::S_FIN;
      end

      fpsched_pkg::S_FIN: begin
        seen_nxt      = 1'b1;
        last_move_nxt = ms_r;
        res_move_nxt  = 1'b1;
        res_ms_nxt    = since_ms;
        // render when not behind by more than a period, or render is stale
        res_rend_nxt  = !alu_neg || stale;
        if (!alu_neg || stale) begin
          last_rend_nxt = ms_r;
        end
        state_nxt = fpsched_pkg::S_DONE;
      end

      fpsched_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, res_ms_r, res_rend_r, res_move_r};
          state_nxt     = fpsched_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = fpsched_pkg::S_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpsched_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      tpm_r       <= fpsched_pkg::TPM_W'(1000);
      max_fps_r   <= FPS_W'(40);
      min_fps_r   <= FPS_W'(10);
      ro_en_r     <= 1'b1;
      fixed_r     <= 1'b1;
      dl_r        <= '0;
      last_move_r <= '0;
      last_rend_r <= '0;
      seen_r      <= 1'b0;
      div_cnt_r   <= '0;
      div_min_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tpm_r       <= tpm_nxt;
      max_fps_r   <= max_fps_nxt;
      min_fps_r   <= min_fps_nxt;
      ro_en_r     <= ro_en_nxt;
      fixed_r     <= fixed_nxt;
      dl_r        <= dl_nxt;
      last_move_r <= last_move_nxt;
      last_rend_r <= last_rend_nxt;
      seen_r      <= seen_nxt;
      div_cnt_r   <= div_cnt_nxt;
      div_min_r   <= div_min_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    now_r       <= now_nxt;
    ms_r        <= ms_nxt;
    prod_r      <= prod_nxt;
    period_r    <= period_nxt;
    cap_r       <= cap_nxt;
    adv_r       <= adv_nxt;
    p100_r      <= p100_nxt;
    el_r        <= el_nxt;
    lag_r       <= lag_nxt;
    res_move_r  <= res_move_nxt;
    res_rend_r  <= res_rend_nxt;
    res_ms_r    <= res_ms_nxt;
    div_q_r     <= div_q_nxt;
    div_rem_r   <= div_rem_nxt;
    div_d_r     <= div_d_nxt;
  end

endmodule

@@ sv/fpsched_chk.sv @@
// ----------------------------------------------------------------------------
// fpsched_chk
// Port-level checks on the frame pacing scheduler, bound to its top level.
// ----------------------------------------------------------------------------
module fpsched_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [fpsched_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // one beat at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a beat is in work");

  // render-only result carries elapsed of one
  a_render_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] && out_tdata[1] |-> out_tdata[33:2] == 32'd1)
    else $error("render-only result with wrong elapsed_ms");

  // neither move nor render carries zero elapsed
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] && !out_tdata[1] |-> out_tdata[33:2] == 32'd0)
    else $error("empty result with nonzero elapsed_ms");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind frame_pacing_skip_scheduler_core fpsched_chk u_fpsched_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ bench/frame_pacing_skip_scheduler_core_tb.sv @@
// ----------------------------------------------------------------------------
// frame_pacing_skip_scheduler_core_tb
// Self-checking bench for the frame pacing scheduler. Frame checks, resyncs
// and deadline resets go in as stream beats. Each result beat is compared
// against an untimed model of the pacing decision. The run covers corner
// register settings, random frame timelines and several idle and stall
// patterns on both streams.
// ----------------------------------------------------------------------------
module frame_pacing_skip_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpsched_pkg::*;

  // tuser code that the block must ignore (still answers with a zero beat)
  localparam logic [MODE_W-1:0]  MODE_UNUSED   = 2'd3;
  localparam int unsigned        TICK_MS_SCALE = 1000;
  localparam logic signed [65:0] GAP_PERIODS   = 66'sd100;
  localparam logic [MS_W-1:0]    STALE_MS      = 32'd5000;
  localparam logic [FINE_W-1:0]  FINE_MAX      = '1;

  typedef struct packed {
    logic            do_move;
    logic            do_render;
    logic [MS_W-1:0] elapsed_ms;
  } decision_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [62:0] fine_tick, [94:63] ms_tick, [95] zero
  logic [MODE_W-1:0]      in_tuser;   // [1:0] mode
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [0] do_move, [1] do_render, [33:2] elapsed_ms
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  frame_pacing_skip_scheduler_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Register mirror, at reset defaults.
  logic [TPM_W-1:0] cur_tpm         = 32'd1000;
  logic [FPS_W-1:0] cur_max_fps     = 10'd40;
  logic [FPS_W-1:0] cur_min_fps     = 10'd10;
  logic             cur_render_only = 1'b1;
  logic             cur_fixed       = 1'b1;

  // Pacing state. The deadline is kept wider than 64 bits so that the
  // elapsed-time arithmetic is exact.
  logic signed [65:0] deadline    = '0;
  logic [MS_W-1:0]    move_mark   = '0;
  logic [MS_W-1:0]    render_mark = '0;
  logic               moved_once  = 1'b0;

  decision_t pending_decisions[$];
  int        mismatch_cnt = 0;
  int        in_idle_pct  = 0;
  int        out_idle_pct = 0;
  int        rx_hold_left = 0;   // long receiver hold-off, counted down per cycle
  bit        offering     = 1'b0; // in_tvalid is (or is about to be) high

  // timeline of the random frame traffic
  logic [FINE_W-1:0] t_fine;
  logic [MS_W-1:0]   t_ms;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Pacing model
  // --------------------------------------------------------------------------
  function automatic logic signed [65:0] period_of(logic [FPS_W-1:0] fps);
    logic [65:0] div;
    div = (fps == '0) ? 66'd1 : 66'(fps);
    return $signed((66'(cur_tpm) * TICK_MS_SCALE) / div);
  endfunction

  // Works out the decision for one accepted beat and advances the state.
  function automatic decision_t next_decision(logic [MODE_W-1:0] mode,
                                              logic [FINE_W-1:0] fine,
                                              logic [MS_W-1:0] ms);
    logic signed [65:0] now, per, elapsed, cap, step;
    logic [MS_W-1:0]    age;
    decision_t          r;
    r   = '0;
    now = $signed({3'b000, fine});
    case (mode)
      MODE_RESYNC: begin
        deadline  = now;
        move_mark = ms;
      end
      MODE_DL_RESET: begin
        deadline = now;
      end
      MODE_CHECK: begin
        per     = period_of(cur_max_fps);
        elapsed = now - deadline;
        // a long gap (pause, debugger) counts as one period
        if (elapsed > per * GAP_PERIODS) begin
          elapsed  = per;
          deadline = now - per;
        end
        if (elapsed >= per) begin
          if (!cur_fixed) begin
            cap  = (cur_min_fps != '0) ? period_of(cur_min_fps) : per;
            step = (elapsed < cap) ? elapsed : cap;
          end else begin
            step = per;
          end
          deadline     = deadline + step;
          moved_once   = 1'b1;
          r.do_move    = 1'b1;
          r.elapsed_ms = ms - move_mark;
          move_mark    = ms;
          age          = ms - render_mark;
          // skip the draw while behind, unless the screen has gone stale
          if ((now - deadline) <= per || age > STALE_MS) begin
            render_mark = ms;
            r.do_render = 1'b1;
          end
        end else if (cur_render_only) begin
          render_mark  = ms;
          r.do_move    = !moved_once;
          r.do_render  = 1'b1;
          r.elapsed_ms = 32'd1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    decision_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.do_move    = out_tdata[0];
      got.do_render  = out_tdata[1];
      got.elapsed_ms = out_tdata[33:2];
      if (pending_decisions.size() == 0) begin
        flag_mismatch("result beat with nothing pending", 64'(out_tdata), '0);
      end else begin
        want = pending_decisions.pop_front();
        if (got.do_move !== want.do_move)
          flag_mismatch("do_move", 64'(got.do_move), 64'(want.do_move));
        if (got.do_render !== want.do_render)
          flag_mismatch("do_render", 64'(got.do_render), 64'(want.do_render));
        if (got.elapsed_ms !== want.elapsed_ms)
          flag_mismatch("elapsed_ms", 64'(got.elapsed_ms), 64'(want.elapsed_ms));
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_tready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("frame_pacing_skip_scheduler_core regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Stop offering and wait until every pending result beat has come back.
  task automatic drain();
    if (offering) in_tvalid <= 1'b0;
    offering = 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
  endtask

  // cfg_valid stays high between back-to-back writes; set_config drops it.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TICKS_PER_MS: cur_tpm         = data;
      CFG_MAX_FPS:      cur_max_fps     = data[FPS_W-1:0];
      CFG_MIN_FPS:      cur_min_fps     = data[FPS_W-1:0];
      CFG_RENDER_ONLY:  cur_render_only = data[0];
      CFG_FIXED_FRAME:  cur_fixed       = data[0];
      default: ;
    endcase
  endtask

  // All five registers, written only once the block has gone idle.
  task automatic set_config(logic [31:0] tpm, logic [31:0] max_fps, logic [31:0] min_fps,
                            logic render_only, logic fixed);
    drain();
    write_reg(CFG_TICKS_PER_MS, tpm);
    write_reg(CFG_MAX_FPS, max_fps);
    write_reg(CFG_MIN_FPS, min_fps);
    write_reg(CFG_RENDER_ONLY, {31'b0, render_only});
    write_reg(CFG_FIXED_FRAME, {31'b0, fixed});
    cfg_valid <= 1'b0;
  endtask

  // Offer one beat, optionally after a random gap. in_tvalid is left high so
  // that a following beat goes out back to back.
  task automatic send_beat(logic [MODE_W-1:0] mode, logic [FINE_W-1:0] fine,
                           logic [MS_W-1:0] ms);
    int gap;
    if ($urandom_range(99) < in_idle_pct) begin
      // mostly short gaps, some long enough to straddle a whole frame check
      gap = ($urandom_range(3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 6);
      if (offering) in_tvalid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {1'b0, ms, fine};
    offering  = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_decisions.push_back(next_decision(mode, fine, ms));
  endtask

  task automatic random_config();
    logic [31:0] tpm, max_fps, min_fps;
    case ($urandom_range(9))
      0:       tpm = 32'd0;
      1:       tpm = 32'hFFFF_FFFF;
      2:       tpm = $urandom_range(1, 20);
      3, 4:    tpm = 32'd1000;
      5:       tpm = 32'd10000;
      6:       tpm = 32'd3_000_000;
      default: tpm = $urandom;
    endcase
    case ($urandom_range(11))
      0:       max_fps = 32'd0;
      1:       max_fps = 32'd1;
      2:       max_fps = 32'd999;
      3:       max_fps = 32'd1023;
      default: max_fps = $urandom_range(1, 999);
    endcase
    case ($urandom_range(9))
      0:       min_fps = 32'd0;
      1:       min_fps = 32'd1;
      2:       min_fps = 32'd999;
      default: min_fps = $urandom_range(1, 999);
    endcase
    set_config(tpm, max_fps, min_fps, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // One beat of a frame timeline: mostly checks spaced around the period,
  // with long gaps, clock steps backward, wild ticks and sync events mixed in.
  task automatic send_random_item();
    logic signed [65:0] p;
    logic [FINE_W-1:0]  per;
    int                 pick;
    p    = period_of(cur_max_fps);
    per  = p[FINE_W-1:0];
    pick = $urandom_range(99);
    if (pick < 70) begin
      t_fine += FINE_W'((64'(per) * $urandom_range(0, 300)) / 100)
              + FINE_W'($urandom_range(0, 3));
      t_ms   += ($urandom_range(15) == 0) ? $urandom_range(5001, 40000)
                                          : $urandom_range(0, 80);
      send_beat(MODE_CHECK, t_fine, t_ms);
    end else if (pick < 78) begin
      t_fine += FINE_W'(64'(per) * $urandom_range(101, 400)) + FINE_W'($urandom_range(0, 999));
      t_ms   += $urandom_range(0, 9000);
      send_beat(MODE_CHECK, t_fine, t_ms);
    end else if (pick < 83) begin
      t_fine -= FINE_W'(64'(per) * $urandom_range(0, 2)) + FINE_W'($urandom_range(1, 50));
      send_beat(MODE_CHECK, t_fine, t_ms);
    end else if (pick < 87) begin
      t_fine = FINE_W'({$urandom, $urandom});
      t_ms   = $urandom;
      send_beat(MODE_CHECK, t_fine, t_ms);
    end else if (pick < 93) begin
      send_beat(MODE_RESYNC, t_fine, t_ms);
    end else if (pick < 97) begin
      send_beat(MODE_DL_RESET, t_fine, t_ms);
    end else begin
      send_beat(MODE_UNUSED, FINE_W'({$urandom, $urandom}), $urandom);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset defaults, 25000-tick period: first frames and a huge gap.
  task automatic test_first_frames();
    send_beat(MODE_CHECK, 63'd0, 32'd0);          // render-only before any move
    send_beat(MODE_CHECK, 63'd25_000, 32'd25);    // first move
    send_beat(MODE_CHECK, 63'd30_000, 32'd30);    // render-only after a move
    send_beat(MODE_CHECK, FINE_MAX, 32'hFFFF_FFFF); // gap clamped to one period
  endtask

  task automatic test_sync_events();
    send_beat(MODE_RESYNC, 63'd1_000_000, 32'hFFFF_FFF0);
    send_beat(MODE_CHECK, 63'd1_025_000, 32'h0000_0009); // ms tick wrapped
    send_beat(MODE_DL_RESET, 63'd2_000_000, 32'd100);
    send_beat(MODE_CHECK, 63'd2_030_000, 32'd130);
    send_beat(MODE_UNUSED, FINE_MAX, 32'hFFFF_FFFF);
    send_beat(MODE_CHECK, 63'd1_000, 32'd140);  // fine tick behind the deadline
  endtask

  task automatic test_config_corners();
    // zero max_fps acts as 1 fps; render-only off gives zero beats between frames
    set_config(32'd1000, 32'd0, 32'd10, 1'b0, 1'b1);
    send_beat(MODE_RESYNC, 63'd0, 32'd0);
    send_beat(MODE_CHECK, 63'd500_000, 32'd500);
    send_beat(MODE_CHECK, 63'd1_000_000, 32'd1000);
    // variable advance, zero min_fps caps at the max_fps period
    set_config(32'd1000, 32'd40, 32'd0, 1'b1, 1'b0);
    send_beat(MODE_RESYNC, 63'd0, 32'd0);
    send_beat(MODE_CHECK, 63'd75_000, 32'd75);
    // variable advance under a wide 1 fps cap
    set_config(32'd1000, 32'd40, 32'd1, 1'b1, 1'b0);
    send_beat(MODE_CHECK, 63'd300_000, 32'd300);
    // zero ticks_per_ms: zero period, every check not behind is a move
    set_config(32'd0, 32'd999, 32'd999, 1'b1, 1'b1);
    send_beat(MODE_CHECK, 63'd400, 32'd301);
    send_beat(MODE_CHECK, 63'd3, 32'd302);
    // largest period; upper cfg_data bits of max_fps are dropped
    set_config(32'hFFFF_FFFF, 32'hFFFF_FC01, 32'd1023, 1'b1, 1'b0);
    send_beat(MODE_CHECK, FINE_MAX, 32'd303);
  endtask

  // Falling behind suppresses the draw until the last render is over 5 s old.
  task automatic test_stale_render();
    set_config(32'd1000, 32'd40, 32'd10, 1'b1, 1'b1);
    send_beat(MODE_RESYNC, 63'd0, 32'd0);
    send_beat(MODE_CHECK, 63'd250_000, 32'd250);
    send_beat(MODE_CHECK, 63'd260_000, 32'd6000);
  endtask

  // Receiver holds off while the sender keeps offering: the output register
  // and the finished result fill up and in_tready stays low.
  task automatic test_backpressure();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    t_fine       = 63'd5_000_000;
    t_ms         = 32'd7000;
    rx_hold_left = 600;
    repeat (12) send_random_item();
    drain();
  endtask

  task automatic test_random_traffic(int n_items, int in_pct, int out_pct);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    t_fine       = FINE_W'({$urandom, $urandom}) >> $urandom_range(0, 40);
    t_ms         = $urandom;
    for (int i = 0; i < n_items; i++) begin
      // fresh register setting every hundred beats, timeline resynced
      if (i % 100 == 0) begin
        random_config();
        send_beat(MODE_RESYNC, t_fine, t_ms);
      end else begin
        send_random_item();
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_CHECK;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_TICKS_PER_MS;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    in_idle_pct  = 20;
    out_idle_pct = 30;
    test_first_frames();
    test_sync_events();
    test_config_corners();
    test_stale_render();
    test_backpressure();
    test_random_traffic(400, 7, 81);
    test_random_traffic(400, 81, 7);
    test_random_traffic(400, 0, 0);

    drain();
    // catch any stray beat after the last expected one
    repeat (200) @(posedge clk);
    if (mismatch_cnt == 0 && pending_decisions.size() == 0) begin
      $display("frame_pacing_skip_scheduler_core regression: pass");
    end else begin
      $display("frame_pacing_skip_scheduler_core regression: fail");
    end
    $finish;
  end

endmodule
